>>> design/ljf_pkg.sv
// shared types and constants for the lennard-jones pair force pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ljf_pkg;

	// restoring divider length, one quotient bit per stage
	localparam int DIV_STEPS = 80;
	localparam int FRONT_LAT = 4;
	localparam int POW_LAT   = 7;
	localparam int SCALE_LAT = 3;
	localparam int LATENCY   = FRONT_LAT + 2 * DIV_STEPS + POW_LAT + SCALE_LAT;

	localparam logic [47:0] COEF_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] COEF_MIN = 48'h8000_0000_0000;
	localparam logic [62:0] D2_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [59:0] SIX_Q32  = 60'h6_0000_0000;

	localparam logic [30:0] BOX_RESET  = 31'h0001_0000;
	localparam logic [31:0] WELL_RESET = 32'h0001_0000;

	typedef enum logic [1:0] {
		REG_BOX_X = 2'd0,
		REG_BOX_Y = 2'd1,
		REG_WELL  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [30:0] box_x;
		logic [30:0] box_y;
		logic [31:0] well;
	} cfg_t;

	// per-item data leaving the front end
	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic [62:0]        d2;
		logic               zero;
		logic               esat;
	} early_t;

	// flags produced after the power stages
	typedef struct packed {
		logic neg;
		logic ysat;
	} late_t;

	// flags handed to the scaling stages
	typedef struct packed {
		logic zero;
		logic esat;
		logic neg;
		logic ysat;
	} lj_flags_t;

endpackage

>>> design/pair_lj_force_coefficient.sv
// top level of the lennard-jones pair force pipeline
// depends on ljf_pkg, ljf_regs, ljf_front, ljf_div, ljf_power, ljf_scale
`timescale 1ns / 1ps

// a new pair item can enter on every clock unless the output stalls; the
// pipeline has 174 register stages (4 front-end stages, two 80-stage
// bit-per-cycle dividers for the distance ratio and the final division by
// d2, 7 power stages and 3 scaling stages), the last being the output
// register. the dividers make up most of the depth; throughput is one item
// per cycle while the output drains. when out_ready is low with a result
// waiting, the whole pipeline holds, so in_ready follows out_ready while
// the output is full. configuration registers sit on the apb port at 0x0
// (box x), 0x4 (box y) and 0x8 (well depth) and should only be written
// while no item is in flight.
module pair_lj_force_coefficient (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_a_x,
	input  logic signed [31:0] pos_a_y,
	input  logic signed [31:0] pos_a_z,
	input  logic signed [31:0] pos_b_x,
	input  logic signed [31:0] pos_b_y,
	input  logic signed [31:0] pos_b_z,
	input  logic [23:0]        radius_a,
	input  logic [23:0]        radius_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] delta_x,
	output logic signed [31:0] delta_y,
	output logic signed [31:0] delta_z,
	output logic [62:0]        distance_squared,
	output logic signed [47:0] force_coef,
	output logic               out_of_range
);
	import ljf_pkg::*;

	// side line taps; element k of the early line holds pipeline stage FRONT_LAT+k+1
	localparam int EARLY_LEN = LATENCY - FRONT_LAT;
	localparam int TAP_DIV2  = DIV_STEPS + POW_LAT - 1;
	localparam int TAP_SCALE = 2 * DIV_STEPS + POW_LAT - 1;
	localparam int TAP_OUT   = EARLY_LEN - 1;

	cfg_t        cfg;
	logic        en;
	logic        valid_q [LATENCY];

	early_t      early;
	logic [49:0] rsq;
	early_t      early_q [EARLY_LEN];
	late_t       late_q  [DIV_STEPS];

	logic [79:0]  quo1, quo2;
	logic [115:0] prod;
	logic         neg;
	lj_flags_t    flags;
	logic [47:0]  coef;
	logic         flag;
	logic         ysat;

	// global advance: the pipeline moves whenever the output can drain
	assign en        = ~valid_q[LATENCY-1] | out_ready;
	assign in_ready  = en;
	assign out_valid = valid_q[LATENCY-1];

	ljf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ljf_front u_front (
		.clk      (clk),
		.en       (en),
		.pos_a_x  (pos_a_x),
		.pos_a_y  (pos_a_y),
		.pos_a_z  (pos_a_z),
		.pos_b_x  (pos_b_x),
		.pos_b_y  (pos_b_y),
		.pos_b_z  (pos_b_z),
		.radius_a (radius_a),
		.radius_b (radius_b),
		.box_x    (cfg.box_x),
		.box_y    (cfg.box_y),
		.early    (early),
		.rsq      (rsq)
	);

	// ratio (ra+rb)^2 / d2 in q.32; below 256 when it matters
	ljf_div u_div_ratio (
		.clk    (clk),
		.en     (en),
		.rem_in (64'(rsq[49:48])),
		.num_in ({rsq[47:0], 32'b0}),
		.den_in (early.d2),
		.quo    (quo1)
	);

	ljf_power u_power (
		.clk  (clk),
		.en   (en),
		.q    (quo1[39:0]),
		.prod (prod),
		.neg  (neg)
	);

	// quotient at or above 2^80 can never fit the coefficient
	assign ysat = (63'(prod[115:70]) >= early_q[TAP_DIV2].d2);

	ljf_div u_div_force (
		.clk    (clk),
		.en     (en),
		.rem_in (64'(prod[115:70])),
		.num_in ({prod[69:0], 10'b0}),
		.den_in (early_q[TAP_DIV2].d2),
		.quo    (quo2)
	);

	assign flags.zero = early_q[TAP_SCALE].zero;
	assign flags.esat = early_q[TAP_SCALE].esat;
	assign flags.neg  = late_q[DIV_STEPS-1].neg;
	assign flags.ysat = late_q[DIV_STEPS-1].ysat;

	ljf_scale u_scale (
		.clk   (clk),
		.en    (en),
		.y     (quo2),
		.wd    (cfg.well),
		.flags (flags),
		.coef  (coef),
		.flag  (flag)
	);

	// valid bits, one per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LATENCY; k++)
				valid_q[k] <= 1'b0;
		end else if (en) begin
			valid_q[0] <= in_valid;
			for (int k = 1; k < LATENCY; k++)
				valid_q[k] <= valid_q[k-1];
		end
	end

	// side lines carrying deltas, d2 and flags alongside the arithmetic
	always_ff @(posedge clk) begin
		if (en) begin
			early_q[0] <= early;
			for (int k = 1; k < EARLY_LEN; k++)
				early_q[k] <= early_q[k-1];
			late_q[0].neg  <= neg;
			late_q[0].ysat <= ysat;
			for (int k = 1; k < DIV_STEPS; k++)
				late_q[k] <= late_q[k-1];
		end
	end

	assign delta_x          = early_q[TAP_OUT].dx;
	assign delta_y          = early_q[TAP_OUT].dy;
	assign delta_z          = early_q[TAP_OUT].dz;
	assign distance_squared = early_q[TAP_OUT].d2;
	assign force_coef       = $signed(coef);
	assign out_of_range     = flag;

	// zero distance always reports the positive limit with the flag
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && distance_squared == '0 |-> out_of_range && coef == COEF_MAX)
		else $error("zero distance result wrong");

	// zero epsilon with nonzero distance gives a clean zero
	a_zero_eps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && distance_squared != '0 && cfg.well == '0
		|-> !out_of_range && coef == '0)
		else $error("zero epsilon result wrong");

	// a flagged result sits at one of the two limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> coef == COEF_MAX || coef == COEF_MIN)
		else $error("flagged coefficient not saturated");

endmodule

>>> design/ljf_regs.sv
// apb configuration registers: box lengths and well depth
// depends on ljf_pkg
`timescale 1ns / 1ps

module ljf_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output ljf_pkg::cfg_t cfg
);
	import ljf_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_x <= BOX_RESET;
			cfg_q.box_y <= BOX_RESET;
			cfg_q.well  <= WELL_RESET;
		end else if (wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_BOX_X: cfg_q.box_x <= pwdata[30:0];
				REG_BOX_Y: cfg_q.box_y <= pwdata[30:0];
				REG_WELL:  cfg_q.well  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_BOX_X: prdata = {1'b0, cfg_q.box_x};
			REG_BOX_Y: prdata = {1'b0, cfg_q.box_y};
			REG_WELL:  prdata = cfg_q.well;
			default:   prdata = '0;
		endcase
	end

endmodule

>>> design/ljf_front.sv
// front end: minimum-image x and y deltas, plain z delta, squared distance, radius sum squared
// depends on ljf_pkg; four register stages
`timescale 1ns / 1ps

module ljf_front (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] pos_a_x,
	input  logic signed [31:0] pos_a_y,
	input  logic signed [31:0] pos_a_z,
	input  logic signed [31:0] pos_b_x,
	input  logic signed [31:0] pos_b_y,
	input  logic signed [31:0] pos_b_z,
	input  logic [23:0]        radius_a,
	input  logic [23:0]        radius_b,
	input  logic [30:0]        box_x,
	input  logic [30:0]        box_y,
	output ljf_pkg::early_t    early,
	output logic [49:0]        rsq
);
	import ljf_pkg::*;

	localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
	localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX)
			r = 32'sh7FFF_FFFF;
		else if (v < S32_MIN)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] wrap_diff(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic [30:0] len);
		logic signed [33:0] d;
		logic signed [33:0] l;
		logic signed [33:0] w;
		d = 34'(a) - 34'(b);
		l = $signed({3'b000, len});
		if ((d <<< 1) > l)
			w = d - l;
		else if ((d <<< 1) <= -l)
			w = d + l;
		else
			w = d;
		return sat32(w);
	endfunction

	function automatic logic [63:0] sq32(input logic signed [31:0] a);
		logic signed [63:0] p;
		p = 64'(a) * 64'(a);
		return p;
	endfunction

	logic signed [31:0] dx_s1, dy_s1, dz_s1, dx_s2, dy_s2, dz_s2;
	logic signed [31:0] dx_s3, dy_s3, dz_s3, dx_s4, dy_s4, dz_s4;
	logic [24:0]        rsum_s1;
	logic [63:0]        sqx_s2, sqy_s2, sqz_s2;
	logic [49:0]        rs_s2, rs_s3, rs_s4;
	logic [62:0]        d2_s3, d2_s4;
	logic               zero_s4, esat_s4;
	logic [63:0]        sum;

	assign sum = sqx_s2 + sqy_s2 + sqz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= wrap_diff(pos_a_x, pos_b_x, box_x);
			dy_s1   <= wrap_diff(pos_a_y, pos_b_y, box_y);
			dz_s1   <= sat32(34'(pos_a_z) - 34'(pos_b_z));
			rsum_s1 <= 25'(radius_a) + 25'(radius_b);

			sqx_s2 <= sq32(dx_s1);
			sqy_s2 <= sq32(dy_s1);
			sqz_s2 <= sq32(dz_s1);
			rs_s2  <= 50'(rsum_s1) * 50'(rsum_s1);
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dz_s2  <= dz_s1;

			d2_s3 <= sum[63] ? D2_MAX : sum[62:0];
			rs_s3 <= rs_s2;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			dz_s3 <= dz_s2;

			zero_s4 <= (d2_s3 == '0);
			esat_s4 <= (63'(rs_s3[49:8]) >= d2_s3);
			d2_s4   <= d2_s3;
			rs_s4   <= rs_s3;
			dx_s4   <= dx_s3;
			dy_s4   <= dy_s3;
			dz_s4   <= dz_s3;
		end
	end

	assign early.dx   = dx_s4;
	assign early.dy   = dy_s4;
	assign early.dz   = dz_s4;
	assign early.d2   = d2_s4;
	assign early.zero = zero_s4;
	assign early.esat = esat_s4;
	assign rsq        = rs_s4;

endmodule

>>> design/ljf_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on ljf_pkg for the stage count
`timescale 1ns / 1ps

module ljf_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rem_in,
	input  logic [79:0] num_in,
	input  logic [62:0] den_in,
	output logic [79:0] quo
);
	import ljf_pkg::*;

	// per stage: partial remainder, numerator bits left plus quotient bits so far
	logic [63:0] rem_s  [DIV_STEPS];
	logic [79:0] bits_s [DIV_STEPS];
	logic [62:0] den_s  [DIV_STEPS];
	logic [63:0] rem_nx [DIV_STEPS];
	logic [79:0] bits_nx[DIV_STEPS];
	logic [62:0] den_nx [DIV_STEPS];

	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			logic [63:0] r;
			logic [79:0] b;
			logic [62:0] d;
			logic [63:0] t;
			logic        ge;
			r  = (k == 0) ? rem_in : rem_s[(k == 0) ? 0 : k - 1];
			b  = (k == 0) ? num_in : bits_s[(k == 0) ? 0 : k - 1];
			d  = (k == 0) ? den_in : den_s[(k == 0) ? 0 : k - 1];
			t  = {r[62:0], b[79]};
			ge = (t >= {1'b0, d});
			rem_nx[k]  = ge ? t - {1'b0, d} : t;
			bits_nx[k] = {b[78:0], ge};
			den_nx[k]  = d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				rem_s[k]  <= rem_nx[k];
				bits_s[k] <= bits_nx[k];
				den_s[k]  <= den_nx[k];
			end
		end
	end

	assign quo = bits_s[DIV_STEPS-1];

endmodule

>>> design/ljf_power.sv
// ratio powers: q^3 truncated, 12*s6-6 and the product s6*|t|
// depends on ljf_pkg; seven register stages, multipliers split to 32 bits
`timescale 1ns / 1ps

module ljf_power (
	input  logic         clk,
	input  logic         en,
	input  logic [39:0]  q,
	output logic [115:0] prod,
	output logic         neg
);
	import ljf_pkg::*;

	logic [63:0]  ll_s1;
	logic [39:0]  hl_s1;
	logic [39:0]  q_s1, q_s2;
	logic [47:0]  q2_s2;
	logic [63:0]  ll_s3;
	logic [39:0]  lh_s3;
	logic [47:0]  hl_s3;
	logic [23:0]  hh_s3;
	logic [55:0]  s6_s4, s6_s5;
	logic [59:0]  mag_s5;
	logic         neg_s5, neg_s6, neg_s7;
	logic [63:0]  p00_s6;
	logic [59:0]  p01_s6;
	logic [55:0]  p10_s6;
	logic [51:0]  p11_s6;
	logic [115:0] prod_s7;

	logic [79:0]  sq_sum;
	logic [87:0]  cu_sum;
	logic [59:0]  tw;
	logic [115:0] pr_sum;

	always_comb begin
		sq_sum = 80'({16'(q_s1[39:32]) * 16'(q_s1[39:32]), 64'b0})
			+ 80'({hl_s1, 33'b0}) + 80'(ll_s1);
		cu_sum = 88'(ll_s3) + 88'({lh_s3, 32'b0}) + 88'({hl_s3, 32'b0})
			+ 88'({hh_s3, 64'b0});
		tw     = 60'({s6_s4, 3'b000}) + 60'({s6_s4, 2'b00});
		pr_sum = 116'(p00_s6) + 116'({p01_s6, 32'b0}) + 116'({p10_s6, 32'b0})
			+ 116'({p11_s6, 64'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(q[31:0]) * 64'(q[31:0]);
			hl_s1 <= 40'(q[39:32]) * 40'(q[31:0]);
			q_s1  <= q;

			q2_s2 <= sq_sum[79:32];
			q_s2  <= q_s1;

			ll_s3 <= 64'(q2_s2[31:0]) * 64'(q_s2[31:0]);
			lh_s3 <= 40'(q2_s2[31:0]) * 40'(q_s2[39:32]);
			hl_s3 <= 48'(q2_s2[47:32]) * 48'(q_s2[31:0]);
			hh_s3 <= 24'(q2_s2[47:32]) * 24'(q_s2[39:32]);

			s6_s4 <= cu_sum[87:32];

			s6_s5  <= s6_s4;
			neg_s5 <= (tw < SIX_Q32);
			mag_s5 <= (tw < SIX_Q32) ? SIX_Q32 - tw : tw - SIX_Q32;

			p00_s6 <= 64'(s6_s5[31:0]) * 64'(mag_s5[31:0]);
			p01_s6 <= 60'(s6_s5[31:0]) * 60'(mag_s5[59:32]);
			p10_s6 <= 56'(s6_s5[55:32]) * 56'(mag_s5[31:0]);
			p11_s6 <= 52'(s6_s5[55:32]) * 52'(mag_s5[59:32]);
			neg_s6 <= neg_s5;

			prod_s7 <= pr_sum;
			neg_s7  <= neg_s6;
		end
	end

	assign prod = prod_s7;
	assign neg  = neg_s7;

endmodule

>>> design/ljf_scale.sv
// epsilon scaling and final saturation of the force coefficient
// depends on ljf_pkg; three register stages, the last is the output register
`timescale 1ns / 1ps

module ljf_scale (
	input  logic               clk,
	input  logic               en,
	input  logic [79:0]        y,
	input  logic [31:0]        wd,
	input  ljf_pkg::lj_flags_t flags,
	output logic [47:0]        coef,
	output logic               flag
);
	import ljf_pkg::*;

	logic [63:0] m0_s1, m1_s1;
	logic [47:0] m2_s1;
	lj_flags_t   fl_s1, fl_s2;
	logic        wdz_s1, wdz_s2;
	logic [79:0] mag_s2;
	logic [47:0] coef_s3;
	logic        flag_s3;
	logic [111:0] psum;
	logic        sat, neg_eff;

	always_comb begin
		psum    = 112'(m0_s1) + 112'({m1_s1, 32'b0}) + 112'({m2_s1, 64'b0});
		sat     = fl_s2.esat | fl_s2.ysat
			| (fl_s2.neg ? (mag_s2 > 80'(COEF_MIN)) : (mag_s2 > 80'(COEF_MAX)));
		neg_eff = fl_s2.neg & ~fl_s2.esat;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m0_s1  <= 64'(wd) * 64'(y[31:0]);
			m1_s1  <= 64'(wd) * 64'(y[63:32]);
			m2_s1  <= 48'(wd) * 48'(y[79:64]);
			fl_s1  <= flags;
			wdz_s1 <= (wd == '0);

			mag_s2 <= psum[111:32];
			fl_s2  <= fl_s1;
			wdz_s2 <= wdz_s1;

			if (fl_s2.zero) begin
				coef_s3 <= COEF_MAX;
				flag_s3 <= 1'b1;
			end else if (wdz_s2) begin
				coef_s3 <= '0;
				flag_s3 <= 1'b0;
			end else if (sat) begin
				coef_s3 <= neg_eff ? COEF_MIN : COEF_MAX;
				flag_s3 <= 1'b1;
			end else begin
				coef_s3 <= fl_s2.neg ? 48'(0) - mag_s2[47:0] : mag_s2[47:0];
				flag_s3 <= 1'b0;
			end
		end
	end

	assign coef = coef_s3;
	assign flag = flag_s3;

endmodule

>>> tb/sv/tb.sv
// testbench for the lennard-jones pair force coefficient pipeline
// self-checking: bit-exact predictor, queue-fed driver, clocked monitor; needs ljf_pkg and the dut
`timescale 1ns / 1ps

module tb;
	import ljf_pkg::*;

	// one pair item as offered on the input channel
	typedef struct {
		logic signed [31:0] ax, ay, az, bx, by, bz;
		logic [23:0]        ra, rb;
	} pair_t;

	// one result item as seen on the output channel
	typedef struct {
		logic signed [31:0] dx, dy, dz;
		logic [62:0]        d2;
		logic [47:0]        coef;
		logic               oor;
	} force_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] pos_a_x = '0, pos_a_y = '0, pos_a_z = '0;
	logic signed [31:0] pos_b_x = '0, pos_b_y = '0, pos_b_z = '0;
	logic [23:0] radius_a = '0, radius_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] delta_x, delta_y, delta_z;
	logic [62:0] distance_squared;
	logic signed [47:0] force_coef;
	logic out_of_range;

	pair_lj_force_coefficient i_dut (.*);

	// clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the configuration registers
	logic [30:0] box_x_sh = BOX_RESET;
	logic [30:0] box_y_sh = BOX_RESET;
	logic [31:0] well_sh  = WELL_RESET;

	pair_t  pair_queue[$];
	force_t force_queue[$];
	int     fail_cnt = 0;
	int     item_cnt = 0;
	int     result_cnt = 0;
	int     sat_cnt = 0;
	logic   in_fire = 1'b0;
	bit     long_hold_req = 1'b0;

	// ---------------------------------------------------------------- predictor

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// one periodic correction toward the minimum image, then clamp
	function automatic logic signed [31:0] min_image(logic signed [31:0] a,
			logic signed [31:0] b, logic [30:0] len);
		logic signed [63:0] d;
		logic signed [63:0] l;
		d = 64'(a) - 64'(b);
		l = $signed({33'b0, len});
		if (2 * d > l) d = d - l;
		else if (2 * d <= -l) d = d + l;
		return clamp32(d);
	endfunction

	function automatic force_t lj_force(pair_t p);
		logic signed [63:0] ex, ey, ez;
		logic [63:0]  sum_sq, rsum, rs, q, q2, s6, twelve, mag, m;
		logic [62:0]  d2;
		logic [127:0] num, quo, prod;
		logic         neg, sat;
		force_t       r;
		r.dx = min_image(p.ax, p.bx, box_x_sh);
		r.dy = min_image(p.ay, p.by, box_y_sh);
		r.dz = clamp32(64'(p.az) - 64'(p.bz));
		ex = 64'(r.dx);
		ey = 64'(r.dy);
		ez = 64'(r.dz);
		sum_sq = $unsigned(ex * ex) + $unsigned(ey * ey) + $unsigned(ez * ez);
		d2 = (sum_sq > 64'(D2_MAX)) ? D2_MAX : sum_sq[62:0];
		r.d2 = d2;
		r.coef = '0;
		r.oor = 1'b0;
		neg = 1'b0;
		sat = 1'b0;
		if (d2 == 0) begin
			// coincident particles
			r.coef = COEF_MAX;
			r.oor = 1'b1;
		end else if (well_sh != 0) begin
			rsum = 64'(p.ra) + 64'(p.rb);
			rs = rsum * rsum;
			if ((rs >> 8) >= 64'(d2)) begin
				sat = 1'b1;
			end else begin
				num = 128'(rs) << 32;
				quo = num / 128'(d2);
				q = quo[63:0];
				prod = 128'(q) * 128'(q);
				q2 = prod[95:32];
				prod = 128'(q2) * 128'(q);
				s6 = prod[95:32];
				twelve = 12 * s6;
				if (twelve >= 64'(SIX_Q32)) begin
					mag = twelve - 64'(SIX_Q32);
				end else begin
					mag = 64'(SIX_Q32) - twelve;
					neg = 1'b1;
				end
				prod = 128'(s6) * 128'(mag);
				num = prod << 10;
				quo = num / 128'(d2);
				if (quo[127:80] != 0) begin
					sat = 1'b1;
				end else begin
					prod = 128'(well_sh) * quo;
					if (prod[127:80] != 0) begin
						sat = 1'b1;
					end else begin
						m = prod[95:32];
						if (!neg) begin
							if (m > 64'(COEF_MAX)) sat = 1'b1;
							else r.coef = m[47:0];
						end else begin
							if (m > 64'h8000_0000_0000) sat = 1'b1;
							else r.coef = 48'(~m + 64'd1);
						end
					end
				end
			end
			if (sat) begin
				r.coef = neg ? COEF_MIN : COEF_MAX;
				r.oor = 1'b1;
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- driver

	int burst_left = 0;
	int gap_left = 0;

	// input side: bursts of items separated by random gaps
	always @(negedge clk) begin
		pair_t cur;
		if (arst_n) begin
			if (in_valid && !in_fire) begin
				// hold the item until it is taken
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pair_queue.size() > 0) begin
				cur = pair_queue.pop_front();
				in_valid <= 1'b1;
				pos_a_x <= cur.ax;
				pos_a_y <= cur.ay;
				pos_a_z <= cur.az;
				pos_b_x <= cur.bx;
				pos_b_y <= cur.by;
				pos_b_z <= cur.bz;
				radius_a <= cur.ra;
				radius_b <= cur.rb;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(60, 1);
					// no gap in about a third of the bursts
					gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: randomly redrawn stall modes, plus one long hold
	int stall_mode = 0;
	int stall_tick = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			stall_tick <= stall_tick + 1;
			if (stall_tick % 64 == 0) stall_mode <= $urandom_range(3, 0);
			if (long_hold_req && !hold_done) begin
				// long hold so the pipeline fills and backs up into the input
				hold_done <= 1'b1;
				hold_cnt <= 600;
				out_ready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(3, 0) != 0);
					2: out_ready <= (stall_tick % 5 < 3);
					default: out_ready <= 1'($urandom_range(1, 0));
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	int idle_cycles = 0;

	always @(posedge clk) begin
		force_t e;
		in_fire <= in_valid && in_ready;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (in_valid && in_ready) begin
				force_queue.push_back(lj_force('{pos_a_x, pos_a_y, pos_a_z,
						pos_b_x, pos_b_y, pos_b_z, radius_a, radius_b}));
				item_cnt <= item_cnt + 1;
			end
			if (out_valid && out_ready) begin
				result_cnt <= result_cnt + 1;
				if (out_of_range) sat_cnt <= sat_cnt + 1;
				if (force_queue.size() == 0) begin
					$display("%0t: result item with nothing expected", $time);
					fail_cnt <= fail_cnt + 1;
				end else begin
					e = force_queue.pop_front();
					if (delta_x !== e.dx || delta_y !== e.dy || delta_z !== e.dz ||
							distance_squared !== e.d2 || force_coef !== e.coef ||
							out_of_range !== e.oor) begin
						$display("%0t: mismatch exp dx=%h dy=%h dz=%h d2=%h coef=%h oor=%b",
							$time, e.dx, e.dy, e.dz, e.d2, e.coef, e.oor);
						$display("%0t:          act dx=%h dy=%h dz=%h d2=%h coef=%h oor=%b",
							$time, delta_x, delta_y, delta_z, distance_squared,
							force_coef, out_of_range);
						fail_cnt <= fail_cnt + 1;
					end
				end
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (idle_cycles > 20000) begin
			$display("%0t: timeout", $time);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_BOX_X: box_x_sh = val[30:0];
			REG_BOX_Y: box_y_sh = val[30:0];
			default:   well_sh = val;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(logic [31:0] bx, logic [31:0] by, logic [31:0] w);
		reg_write(REG_BOX_X, bx);
		reg_write(REG_BOX_Y, by);
		reg_write(REG_WELL, w);
	endtask

	// wait until every item has gone through, then let the pipeline settle
	task automatic drain;
		do @(posedge clk);
		while (pair_queue.size() != 0 || in_valid || force_queue.size() != 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic pair_t mk_pair(int ax, int ay, int az, int bx, int by, int bz,
			int ra, int rb);
		pair_t p;
		p = '{ax, ay, az, bx, by, bz, ra[23:0], rb[23:0]};
		return p;
	endfunction

	// coordinate near a base with a random spread of random scale
	function automatic logic signed [31:0] near(logic signed [31:0] base);
		int sh;
		sh = $urandom_range(31, 8);
		return base + ($signed($urandom) >>> sh);
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		logic signed [31:0] c;
		int kind;
		kind = $urandom_range(9, 0);
		if (kind == 0) begin
			// fully random fields
			p.ax = $urandom;
			p.ay = $urandom;
			p.az = $urandom;
			p.bx = $urandom;
			p.by = $urandom;
			p.bz = $urandom;
			p.ra = 24'($urandom);
			p.rb = 24'($urandom);
		end else begin
			// nearby particles with radii on the scale of their distance
			c = $urandom;
			p.ax = near(c);
			p.bx = near(c);
			c = $urandom;
			p.ay = near(c);
			p.by = near(c);
			c = $urandom;
			p.az = near(c);
			p.bz = near(c);
			p.ra = 24'($urandom >> $urandom_range(31, 8));
			p.rb = 24'($urandom >> $urandom_range(31, 8));
			if (kind == 1) p.bz = p.az;
		end
		return p;
	endfunction

	task automatic add_random(int n);
		repeat (n) pair_queue.push_back(rand_pair());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at reset configuration
		pair_queue.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));               // coincident
		pair_queue.push_back(mk_pair(5, -7, 9, 5, -7, 9, 'hFFFFFF, 'hFFFFFF));
		pair_queue.push_back(mk_pair(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 'hFFFFFF, 'hFFFFFF)); // deltas clamp
		pair_queue.push_back(mk_pair(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0));
		pair_queue.push_back(mk_pair(0, 0, 'h10000, 0, 0, 0, 'h8000, 'h8000)); // ratio one
		pair_queue.push_back(mk_pair(0, 0, 'h12000, 0, 0, 0, 'h8000, 'h8000)); // attractive
		pair_queue.push_back(mk_pair(0, 0, 'h100, 0, 0, 0, 'h8000, 'h8000));   // ratio large
		pair_queue.push_back(mk_pair(0, 0, 'h1000, 0, 0, 0, 'h8000, 'h8000));  // near limit
		pair_queue.push_back(mk_pair(0, 0, 1, 0, 0, 0, 'hFFFFFF, 'hFFFFFF));   // tiny distance
		pair_queue.push_back(mk_pair('h8000, 0, 0, 0, 0, 0, 'h100, 0));        // half box
		pair_queue.push_back(mk_pair(-'h8000, 0, 0, 0, 0, 0, 'h100, 0));
		pair_queue.push_back(mk_pair(0, 'h8001, 0, 0, 0, 0, 0, 'h100));
		pair_queue.push_back(mk_pair('h50000, -'h50000, 0, 0, 0, 0, 'h1000, 'h1000)); // outside
		pair_queue.push_back(mk_pair(0, 0, 'h30000, 0, 0, 0, 'h10000, 'h10000));
		pair_queue.push_back(mk_pair(0, 0, 'h7FFFFFFF, 0, 0, 0, 'hFFFFFF, 1));
		add_random(380);
		long_hold_req = 1'b1;
		drain();

		// largest boxes and largest well depth
		set_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
		pair_queue.push_back(mk_pair(0, 0, 'h10000, 0, 0, 0, 'h8000, 'h8000));
		pair_queue.push_back(mk_pair(0, 0, 'h12000, 0, 0, 0, 'h8000, 'h8000));
		pair_queue.push_back(mk_pair(32'h7FFFFFFF, 32'h80000000, 0,
			32'h80000000, 32'h7FFFFFFF, 0, 'h10, 'h10));
		add_random(390);
		drain();

		// boxes of length one, zero well depth
		set_config(32'd1, 32'd1, 32'd0);
		pair_queue.push_back(mk_pair(0, 0, 0, 0, 0, 0, 'h1000, 'h1000));
		pair_queue.push_back(mk_pair(0, 0, 'h10000, 0, 0, 0, 'h8000, 'h8000));
		pair_queue.push_back(mk_pair(1, -1, 0, 0, 0, 0, 'h8000, 'h8000));
		add_random(390);
		drain();

		// random configurations
		repeat (2) begin
			set_config($urandom, $urandom, $urandom);
			add_random(195);
			drain();
		end

		// moderate box and small well depth, bit 31 set in the box writes
		set_config(32'h800A0000, 32'h80140000, 32'h00000100);
		add_random(390);
		drain();

		$display("%0d pair items, %0d results, %0d flagged out of range, six settings",
			item_cnt, result_cnt, sat_cnt);
		if (fail_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
